### rtl/multiturn_position_tracker_drive_macros.svh
// -----------------------------------------------------------------------------
// multiturn position tracker drive assertion macros
// concurrent assertion wrappers, empty when synthesized
// -----------------------------------------------------------------------------
`ifndef MULTITURN_POSITION_TRACKER_DRIVE_MACROS_SVH
`define MULTITURN_POSITION_TRACKER_DRIVE_MACROS_SVH

`ifndef SYNTHESIS

// property checked on every clock edge outside reset
`define MPTD_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition implies an outcome in the following cycle
`define MPTD_ASSERT_NEXT(name, clk, rst_n, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`else

`define MPTD_ASSERT(name, clk, rst_n, prop, msg)
`define MPTD_ASSERT_NEXT(name, clk, rst_n, pre, post, msg)

`endif

`endif

### rtl/mptd_pkg.sv
// -----------------------------------------------------------------------------
// mptd_pkg
// shared widths, reset values and register codes of the position tracker
// -----------------------------------------------------------------------------
package mptd_pkg;

  // default parameter values
  localparam int SampleBitsDef = 12;
  localparam int MaxTurnsDef   = 255;

  // field widths
  localparam int ThrW      = 12;
  localparam int SpanW     = 12;
  localparam int BandW     = 16;
  localparam int LevelW    = 9;
  localparam int TargetW   = 20;
  localparam int PosW      = 20;
  localparam int TurnsOutW = 8;
  localparam int DriveW    = 10;

  // configuration port
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CfgWrapThreshold = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgTurnSpan      = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgCoarseBand    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgFineBand      = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgFastLevel     = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgSlowLevel     = 3'd5;

  // limits
  localparam logic [PosW-1:0]   PosMax   = 20'hFFFFF;
  localparam logic [LevelW-1:0] LevelOne = 9'd256;

  // register reset values
  localparam logic [ThrW-1:0]   WrapThresholdRst = 12'd450;
  localparam logic [SpanW-1:0]  TurnSpanRst      = 12'd964;
  localparam logic [BandW-1:0]  CoarseBandRst    = 16'd100;
  localparam logic [BandW-1:0]  FineBandRst      = 16'd20;
  localparam logic [LevelW-1:0] FastLevelRst     = 9'd128;
  localparam logic [LevelW-1:0] SlowLevelRst     = 9'd26;

  typedef struct packed {
    logic [ThrW-1:0]   wrap_threshold;
    logic [SpanW-1:0]  turn_span;
    logic [BandW-1:0]  coarse_band;
    logic [BandW-1:0]  fine_band;
    logic [LevelW-1:0] fast_level;
    logic [LevelW-1:0] slow_level;
  } cfg_t;

endpackage

### rtl/mptd_if.sv
// -----------------------------------------------------------------------------
// mptd_if
// valid/ready channels carrying sample items in and tracker results out
// -----------------------------------------------------------------------------
interface mptd_in_if #(
  parameter int SAMPLE_BITS = mptd_pkg::SampleBitsDef
);
  logic                             valid;
  logic                             ready;
  logic [SAMPLE_BITS-1:0]           sample;
  logic [mptd_pkg::TargetW-1:0]     target;

  modport source (output valid, output sample, output target, input ready);
  modport sink   (input valid, input sample, input target, output ready);
endinterface

interface mptd_out_if;
  logic                                valid;
  logic                                ready;
  logic [mptd_pkg::PosW-1:0]           position;
  logic [mptd_pkg::TurnsOutW-1:0]      turns;
  logic signed [mptd_pkg::DriveW-1:0]  drive_level;

  modport source (output valid, output position, output turns, output drive_level,
                  input ready);
  modport sink   (input valid, input position, input turns, input drive_level,
                  output ready);
endinterface

### rtl/mptd_unwrap.sv
// -----------------------------------------------------------------------------
// mptd_unwrap
// input register and turn tracking state, one item per cycle while the link is not stalled
// -----------------------------------------------------------------------------
module mptd_unwrap #(
  parameter int SAMPLE_BITS = mptd_pkg::SampleBitsDef,
  parameter int MAX_TURNS   = mptd_pkg::MaxTurnsDef,
  localparam int TurnW      = $clog2(MAX_TURNS + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [mptd_pkg::ThrW-1:0]     wrap_threshold_i,
  mptd_in_if.sink                       in_i,
  output logic                          link_valid_o,
  input  logic                          link_ready_i,
  output logic [SAMPLE_BITS-1:0]        link_sample_o,
  output logic [mptd_pkg::TargetW-1:0]  link_target_o,
  output logic [TurnW-1:0]              link_turns_o
);

  localparam int CmpW = (SAMPLE_BITS > mptd_pkg::ThrW) ? SAMPLE_BITS : mptd_pkg::ThrW;

  // input register
  logic                          a_valid_q;
  logic [SAMPLE_BITS-1:0]        a_sample_q;
  logic [mptd_pkg::TargetW-1:0]  a_target_q;
  logic                          a_ready;
  logic                          a_fire;

  // link register
  logic                          b_valid_q;
  logic [SAMPLE_BITS-1:0]        b_sample_q;
  logic [mptd_pkg::TargetW-1:0]  b_target_q;
  logic [TurnW-1:0]              b_turns_q;
  logic                          b_ready;

  // tracking state
  logic                    started_q, started_d;
  logic                    skip_q, skip_d;
  logic [SAMPLE_BITS-1:0]  prev_q, prev_d;
  logic [TurnW-1:0]        turn_q, turn_d;

  logic [CmpW-1:0] s_ext, p_ext, thr_ext;
  logic            drop, rise;

  assign b_ready    = !b_valid_q || link_ready_i;
  assign a_fire     = a_valid_q && b_ready;
  assign a_ready    = !a_valid_q || b_ready;
  assign in_i.ready = a_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_ready) begin
      a_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && in_i.valid) begin
      a_sample_q <= in_i.sample;
      a_target_q <= in_i.target;
    end
  end

  // jump detection against the previous sample
  assign s_ext   = CmpW'(a_sample_q);
  assign p_ext   = CmpW'(prev_q);
  assign thr_ext = CmpW'(wrap_threshold_i);
  assign drop    = (p_ext > s_ext) && ((p_ext - s_ext) > thr_ext);
  assign rise    = (s_ext > p_ext) && ((s_ext - p_ext) > thr_ext);

  always_comb begin
    started_d = started_q;
    skip_d    = skip_q;
    prev_d    = prev_q;
    turn_d    = turn_q;
    if (a_fire) begin
      prev_d = a_sample_q;
      priority if (!started_q) begin
        started_d = 1'b1;
        turn_d    = '0;
      end else if (skip_q) begin
        skip_d = 1'b0;
      end else if (drop) begin
        if (turn_q < TurnW'(MAX_TURNS)) begin
          turn_d = turn_q + TurnW'(1);
        end
        skip_d = 1'b1;
      end else if (rise) begin
        if (turn_q != '0) begin
          turn_d = turn_q - TurnW'(1);
        end
        skip_d = 1'b1;
      end else begin
        turn_d = turn_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      skip_q    <= 1'b0;
      prev_q    <= '0;
      turn_q    <= '0;
    end else begin
      started_q <= started_d;
      skip_q    <= skip_d;
      prev_q    <= prev_d;
      turn_q    <= turn_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_ready) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_fire) begin
      b_sample_q <= a_sample_q;
      b_target_q <= a_target_q;
      b_turns_q  <= turn_d;
    end
  end

  assign link_valid_o  = b_valid_q;
  assign link_sample_o = b_sample_q;
  assign link_target_o = b_target_q;
  assign link_turns_o  = b_turns_q;

endmodule

### rtl/mptd_drive.sv
// -----------------------------------------------------------------------------
// mptd_drive
// position build with saturation, then error banding into a drive level
// -----------------------------------------------------------------------------
module mptd_drive #(
  parameter int SAMPLE_BITS = mptd_pkg::SampleBitsDef,
  parameter int MAX_TURNS   = mptd_pkg::MaxTurnsDef,
  localparam int TurnW      = $clog2(MAX_TURNS + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mptd_pkg::cfg_t                cfg_i,
  input  logic                          link_valid_i,
  output logic                          link_ready_o,
  input  logic [SAMPLE_BITS-1:0]        link_sample_i,
  input  logic [mptd_pkg::TargetW-1:0]  link_target_i,
  input  logic [TurnW-1:0]              link_turns_i,
  mptd_out_if.source                    out_o
);

  localparam int ProdW = TurnW + mptd_pkg::SpanW;
  localparam int MaxA  = (ProdW > SAMPLE_BITS) ? ProdW : SAMPLE_BITS;
  localparam int SumW  = ((MaxA > mptd_pkg::PosW) ? MaxA : mptd_pkg::PosW) + 1;

  // position stage
  logic                            c_valid_q;
  logic [mptd_pkg::PosW-1:0]       c_pos_q;
  logic [mptd_pkg::TargetW-1:0]    c_target_q;
  logic [mptd_pkg::TurnsOutW-1:0]  c_turns_q;
  logic                            c_ready;
  logic                            c_fire;

  // result register
  logic                              d_valid_q;
  logic [mptd_pkg::PosW-1:0]         d_pos_q;
  logic [mptd_pkg::TurnsOutW-1:0]    d_turns_q;
  logic signed [mptd_pkg::DriveW-1:0] d_drive_q;
  logic                              d_ready;

  logic [ProdW-1:0]               prod;
  logic [SumW-1:0]                sum;
  logic [mptd_pkg::PosW-1:0]      pos_sat;

  logic                           over;
  logic [mptd_pkg::PosW-1:0]      mag;
  logic [mptd_pkg::LevelW-1:0]    fast_lvl, slow_lvl, sel_lvl;
  logic [mptd_pkg::DriveW-1:0]    lvl_ext;
  logic signed [mptd_pkg::DriveW-1:0] drive_d;

  assign d_ready      = !d_valid_q || out_o.ready;
  assign c_fire       = c_valid_q && d_ready;
  assign c_ready      = !c_valid_q || d_ready;
  assign link_ready_o = c_ready;

  // sample plus turns times span, capped at the top of the position range
  assign prod    = ProdW'(link_turns_i) * ProdW'(cfg_i.turn_span);
  assign sum     = SumW'(prod) + SumW'(link_sample_i);
  assign pos_sat = (sum > SumW'(mptd_pkg::PosMax)) ? mptd_pkg::PosMax
                                                    : sum[mptd_pkg::PosW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (c_ready) begin
      c_valid_q <= link_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_ready && link_valid_i) begin
      c_pos_q    <= pos_sat;
      c_target_q <= link_target_i;
      c_turns_q  <= mptd_pkg::TurnsOutW'(link_turns_i);
    end
  end

  // levels above one are used as one
  assign fast_lvl = (cfg_i.fast_level > mptd_pkg::LevelOne) ? mptd_pkg::LevelOne
                                                            : cfg_i.fast_level;
  assign slow_lvl = (cfg_i.slow_level > mptd_pkg::LevelOne) ? mptd_pkg::LevelOne
                                                            : cfg_i.slow_level;

  // position above target drives positive
  assign over = c_pos_q > c_target_q;
  assign mag  = over ? (c_pos_q - c_target_q) : (c_target_q - c_pos_q);

  always_comb begin
    priority if (mag > mptd_pkg::PosW'(cfg_i.coarse_band)) begin
      sel_lvl = fast_lvl;
    end else if (mag > mptd_pkg::PosW'(cfg_i.fine_band)) begin
      sel_lvl = slow_lvl;
    end else begin
      sel_lvl = '0;
    end
  end

  assign lvl_ext = mptd_pkg::DriveW'(sel_lvl);
  assign drive_d = over ? $signed(lvl_ext) : -$signed(lvl_ext);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_valid_q <= 1'b0;
    end else if (d_ready) begin
      d_valid_q <= c_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_fire) begin
      d_pos_q   <= c_pos_q;
      d_turns_q <= c_turns_q;
      d_drive_q <= drive_d;
    end
  end

  assign out_o.valid       = d_valid_q;
  assign out_o.position    = d_pos_q;
  assign out_o.turns       = d_turns_q;
  assign out_o.drive_level = d_drive_q;

endmodule

### rtl/multiturn_position_tracker_drive.sv
// -----------------------------------------------------------------------------
// multiturn_position_tracker_drive
// multi-turn unwrap of single-turn encoder samples with a three-level drive
// -----------------------------------------------------------------------------
//
//  channel   direction  handshake        payload
//  in_i      sink       valid / ready    sample, target
//  out_o     source     valid / ready    position, turns, drive_level
//  cfg       write only cfg_we_i         cfg_idx_i, cfg_wdata_i
//
//  one item per cycle sustained while out_o is ready; after its item is accepted,
//  a result passes the link, position and result registers behind the input register
//  the turn count feeds back to the next item within the single unwrap stage
//  every stage has its own valid bit and takes a new item when it is empty or
//  its content moves on, so a stalled result does not block the input at once
//  reset clears all valid bits and the tracking state and loads the cfg reset values
//
`include "multiturn_position_tracker_drive_macros.svh"

module multiturn_position_tracker_drive #(
  parameter int SAMPLE_BITS = mptd_pkg::SampleBitsDef,
  parameter int MAX_TURNS   = mptd_pkg::MaxTurnsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mptd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [mptd_pkg::CfgDataW-1:0]  cfg_wdata_i,
  mptd_in_if.sink                        in_i,
  mptd_out_if.source                     out_o
);

  localparam int TurnW = $clog2(MAX_TURNS + 1);

  // configuration registers
  mptd_pkg::cfg_t cfg_q, cfg_d;

  // unwrap to drive link
  logic                          link_valid;
  logic                          link_ready;
  logic [SAMPLE_BITS-1:0]        link_sample;
  logic [mptd_pkg::TargetW-1:0]  link_target;
  logic [TurnW-1:0]              link_turns;

  // register writes, unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mptd_pkg::CfgWrapThreshold: cfg_d.wrap_threshold = cfg_wdata_i[mptd_pkg::ThrW-1:0];
        mptd_pkg::CfgTurnSpan:      cfg_d.turn_span      = cfg_wdata_i[mptd_pkg::SpanW-1:0];
        mptd_pkg::CfgCoarseBand:    cfg_d.coarse_band    = cfg_wdata_i[mptd_pkg::BandW-1:0];
        mptd_pkg::CfgFineBand:      cfg_d.fine_band      = cfg_wdata_i[mptd_pkg::BandW-1:0];
        mptd_pkg::CfgFastLevel:     cfg_d.fast_level     = cfg_wdata_i[mptd_pkg::LevelW-1:0];
        mptd_pkg::CfgSlowLevel:     cfg_d.slow_level     = cfg_wdata_i[mptd_pkg::LevelW-1:0];
        default:                    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wrap_threshold <= mptd_pkg::WrapThresholdRst;
      cfg_q.turn_span      <= mptd_pkg::TurnSpanRst;
      cfg_q.coarse_band    <= mptd_pkg::CoarseBandRst;
      cfg_q.fine_band      <= mptd_pkg::FineBandRst;
      cfg_q.fast_level     <= mptd_pkg::FastLevelRst;
      cfg_q.slow_level     <= mptd_pkg::SlowLevelRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // input register, turn tracking and first-sample / skip handling
  mptd_unwrap #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_TURNS   (MAX_TURNS)
  ) u_unwrap (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .wrap_threshold_i (cfg_q.wrap_threshold),
    .in_i             (in_i),
    .link_valid_o     (link_valid),
    .link_ready_i     (link_ready),
    .link_sample_o    (link_sample),
    .link_target_o    (link_target),
    .link_turns_o     (link_turns)
  );

  // position multiply, saturation and drive level select
  mptd_drive #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_TURNS   (MAX_TURNS)
  ) u_drive (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .link_valid_i  (link_valid),
    .link_ready_o  (link_ready),
    .link_sample_i (link_sample),
    .link_target_i (link_target),
    .link_turns_i  (link_turns),
    .out_o         (out_o)
  );

  // turn count stays within its saturation limits
  `MPTD_ASSERT(a_turns_limit, clk_i, rst_ni, link_valid |-> (link_turns <= TurnW'(MAX_TURNS)), "turn count above limit")

  // drive command never exceeds full scale in either direction
  `MPTD_ASSERT(a_drive_range, clk_i, rst_ni, out_o.valid |-> ((out_o.drive_level >= -10'sd256) && (out_o.drive_level <= 10'sd256)), "drive level out of range")

  // a turn span write lands in the register on the next cycle
  `MPTD_ASSERT_NEXT(a_span_write, clk_i, rst_ni, cfg_we_i && (cfg_idx_i == mptd_pkg::CfgTurnSpan), cfg_q.turn_span == $past(cfg_wdata_i[mptd_pkg::SpanW-1:0]), "turn span write lost")

endmodule
